FILE: rtl/core/rtig_pkg.sv
`default_nettype none
package rtig_pkg;

  typedef enum logic [1:0] {
    KIND_WAIT = 2'd0,
    KIND_RUN  = 2'd1,
    KIND_SEND = 2'd2,
    KIND_NOP  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV1,
    ST_DIV2,
    ST_MUL1,
    ST_MUL2,
    ST_COMMIT,
    ST_BAD,
    ST_ADDR1,
    ST_ADDR2,
    ST_EMIT0,
    ST_EMIT1,
    ST_EMIT2,
    ST_NOP
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic div_start;
    logic take_rsize;
    logic take_f;
    logic take_rc;
    logic take_lm;
    logic mul1;
    logic mul2;
    logic commit;
    logic addr1;
    logic addr2;
    logic step;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_busy;
    logic bad;
    logic active;
    logic iters_zero;
  } stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/rtig_if.sv
`default_nettype none
interface rtig_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] row_tiles;
  logic [15:0] col_tiles;
  logic [15:0] depth_tiles;
  logic [7:0]  lhs_bits;
  logic [31:0] result_base;
  modport source (output valid, op, row_tiles, col_tiles, depth_tiles, lhs_bits,
                  result_base, input ready);
  modport sink (input valid, op, row_tiles, col_tiles, depth_tiles, lhs_bits,
                result_base, output ready);
endinterface

interface rtig_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] dram_addr;
  logic        buffer_sel;
  logic [31:0] dram_stride;
  logic        bad_descriptor;
  logic        last;
  modport source (output valid, kind, dram_addr, buffer_sel, dram_stride,
                  bad_descriptor, last, input ready);
  modport sink (input valid, kind, dram_addr, buffer_sel, dram_stride,
                bad_descriptor, last, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/rtig_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module rtig_div import rtig_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [15:0] divisor_i,
  output logic             busy_o,
  output logic [31:0]      quot_o,
  output logic [15:0]      rem_o
);
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] quot_q, quot_d;
  logic [16:0] rem_q, rem_d;
  logic [15:0] dvs_q, dvs_d;
  logic [16:0] trial;

  assign trial = {rem_q[15:0], quot_q[31]};

  always_comb begin
    cnt_d = cnt_q;
    quot_d = quot_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    if (start_i) begin
      cnt_d = 6'd32;
      quot_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
    end else if (cnt_q != 6'd0) begin
      cnt_d = cnt_q - 6'd1;
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = trial - {1'b0, dvs_q};
        quot_d = {quot_q[30:0], 1'b1};
      end else begin
        rem_d = trial;
        quot_d = {quot_q[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = (cnt_q != 6'd0);
  assign quot_o = quot_q;
  assign rem_o = rem_q[15:0];
endmodule
`default_nettype wire

FILE: rtl/core/rtig_datapath.sv
`default_nettype none
module rtig_datapath import rtig_pkg::*; #(
  parameter int unsigned ARRAY_ROWS    = 8,
  parameter int unsigned ARRAY_COLS    = 8,
  parameter int unsigned LHS_MEM_DEPTH = 1024,
  parameter int unsigned ACC_BITS      = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire ctrl_t       ctrl_i,
  output stat_t            stat_o,
  input  wire logic [15:0] row_tiles_i,
  input  wire logic [15:0] col_tiles_i,
  input  wire logic [15:0] depth_tiles_i,
  input  wire logic [7:0]  lhs_bits_i,
  input  wire logic [31:0] result_base_i,
  output logic [31:0]      addr_o,
  output logic             buf_o,
  output logic [31:0]      stride_o
);
  localparam logic [31:0] BytesPerAcc = 32'(ACC_BITS / 8);
  localparam logic [31:0] MemDepth = 32'(LHS_MEM_DEPTH);
  localparam logic [31:0] RowsL = 32'(ARRAY_ROWS);
  localparam logic [31:0] ColsL = 32'(ARRAY_COLS);

  // Latched descriptor.
  logic [15:0] tm_q, tn_q;
  logic [31:0] rb_q, need_q;
  logic        bad_q;
  // Load results.
  logic [15:0] f_q, rc_q, lm_q;
  logic [31:0] prod1_q;
  logic [47:0] total_q;
  logic [15:0] fmul;
  logic [31:0] lm_tn;
  // Run state.
  logic        active_q;
  logic [15:0] cols_total_q, rows_total_q, region_count_q, fetch_count_q;
  logic [15:0] last_chunk_q, row_idx_q, col_idx_q, fetch_idx_q;
  logic [31:0] base_q, stride_q, iters_q, ind1_q, addr_q;
  logic        buf_q;

  logic        div_start;
  logic [31:0] div_dvd, quot;
  logic [15:0] div_dvs, rem;
  logic        div_busy;
  logic [31:0] fceil;
  logic [15:0] fsat;
  logic [16:0] rc_num;

  // Rounded-up fetch count, saturated and never below one.
  assign fceil = quot + ((rem != 16'd0) ? 32'd1 : 32'd0);
  always_comb begin
    if (fceil > 32'hFFFF) fsat = 16'hFFFF;
    else if (fceil == 32'd0) fsat = 16'd1;
    else fsat = fceil[15:0];
  end
  assign rc_num = {1'b0, tm_q} + {1'b0, fsat} - 17'd1;

  // One divider serves the four divisions of a load. Each result is taken
  // in the cycle the divider goes idle, and the next division starts then.
  always_comb begin
    div_start = ctrl_i.div_start | ctrl_i.take_rsize | ctrl_i.take_f | ctrl_i.take_rc;
    div_dvd = MemDepth;
    div_dvs = tm_q;
    if (ctrl_i.take_rsize) begin
      div_dvd = need_q;
      div_dvs = quot[15:0];
    end else if (ctrl_i.take_f) begin
      div_dvd = {15'd0, rc_num};
      div_dvs = fsat;
    end else if (ctrl_i.take_rc) begin
      div_dvd = {16'd0, tm_q};
      div_dvs = quot[15:0];
    end
  end

  rtig_div u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .dividend_i(div_dvd), .divisor_i(div_dvs),
    .busy_o(div_busy), .quot_o(quot), .rem_o(rem)
  );

  // The last chunk takes lm rows instead of a full region.
  assign fmul = (lm_q != 16'd0) ? (f_q - 16'd1) : f_q;
  assign lm_tn = (lm_q != 16'd0) ? ({16'd0, lm_q} * {16'd0, tn_q}) : 32'd0;

  // Descriptor capture and load arithmetic.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_in) begin
      tm_q <= row_tiles_i;
      tn_q <= col_tiles_i;
      rb_q <= result_base_i;
      bad_q <= (row_tiles_i == 16'd0) || ({16'd0, row_tiles_i} > MemDepth);
      need_q <= {16'd0, depth_tiles_i} * {24'd0, lhs_bits_i};
    end
    if (ctrl_i.take_f) f_q <= fsat;
    if (ctrl_i.take_rc) rc_q <= quot[15:0];
    if (ctrl_i.take_lm) lm_q <= rem;
    if (ctrl_i.mul1) prod1_q <= {16'd0, rc_q} * {16'd0, tn_q};
    if (ctrl_i.mul2) total_q <= {16'd0, prod1_q} * {32'd0, fmul} + {16'd0, lm_tn};
  end

  assign stat_o.div_busy = div_busy;
  assign stat_o.bad = bad_q;
  assign stat_o.active = active_q;
  assign stat_o.iters_zero = (iters_q == 32'd0);

  // Next row, column and fetch indices of the tile walk.
  logic [15:0] row_n, col_n, fetch_n;
  logic [31:0] rcl, lfl, m;
  always_comb begin
    rcl = {16'd0, region_count_q};
    lfl = {16'd0, fetch_idx_q};
    row_n = row_idx_q + 16'd1;
    col_n = col_idx_q;
    fetch_n = fetch_idx_q;
    m = {16'd0, row_n};
    if (m == rcl * (lfl + 32'd1) ||
        (m == {16'd0, last_chunk_q} + rcl * lfl &&
         lfl == {16'd0, fetch_count_q} - 32'd1)) begin
      row_n = 16'(rcl * lfl);
      col_n = col_idx_q + 16'd1;
      if (col_n == cols_total_q) begin
        col_n = 16'd0;
        fetch_n = fetch_idx_q + 16'd1;
        row_n = 16'(rcl * {16'd0, fetch_n});
        if (fetch_n == fetch_count_q) fetch_n = 16'd0;
      end
    end
  end

  // Run-state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cols_total_q <= '0; rows_total_q <= '0; region_count_q <= '0;
      fetch_count_q <= '0; last_chunk_q <= '0; row_idx_q <= '0;
      col_idx_q <= '0; fetch_idx_q <= '0; base_q <= '0; stride_q <= '0;
      iters_q <= '0; buf_q <= 1'b0;
    end else begin
      if (ctrl_i.load_in && ((row_tiles_i == 16'd0) ||
                             ({16'd0, row_tiles_i} > MemDepth))) begin
        active_q <= 1'b0;
      end
      if (ctrl_i.commit) begin
        rows_total_q <= tm_q;
        cols_total_q <= tn_q;
        base_q <= rb_q;
        stride_q <= BytesPerAcc * ({16'd0, tm_q} * RowsL);
        fetch_count_q <= f_q;
        region_count_q <= rc_q;
        last_chunk_q <= lm_q;
        iters_q <= (total_q > 48'h0000_FFFF_FFFF) ? 32'hFFFF_FFFF : total_q[31:0];
        row_idx_q <= '0; col_idx_q <= '0; fetch_idx_q <= '0;
        buf_q <= 1'b0;
        active_q <= 1'b1;
      end
      if (ctrl_i.step) begin
        if (iters_q == 32'd0) begin
          active_q <= 1'b0;
        end else begin
          buf_q <= ~buf_q;
          iters_q <= iters_q - 32'd1;
          row_idx_q <= row_n;
          col_idx_q <= col_n;
          fetch_idx_q <= fetch_n;
        end
      end
    end
  end

  // Address is built over two registered steps: column offset, then row and base.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.addr1)
      ind1_q <= (ColsL * {16'd0, col_idx_q}) * ({16'd0, rows_total_q} * RowsL);
    if (ctrl_i.addr2)
      addr_q <= base_q + (ind1_q + RowsL * {16'd0, row_idx_q}) * BytesPerAcc;
  end

  assign addr_o = addr_q;
  assign buf_o = buf_q;
  assign stride_o = stride_q;
endmodule
`default_nettype wire

FILE: rtl/core/rtig_ctrl.sv
`default_nettype none
module rtig_ctrl import rtig_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  input  wire logic  in_op_i,
  output logic       in_ready_o,
  input  wire logic  out_ready_i,
  output logic       out_valid_o,
  output logic [1:0] out_kind_o,
  output logic       out_run_o,
  output logic       out_bad_o,
  output logic       out_last_o,
  input  wire stat_t stat_i,
  output ctrl_t      ctrl_o
);
  state_e state_q, state_d;
  logic [1:0] pass_q, pass_d;
  logic acc, fire;

  assign acc = in_valid_i & in_ready_o;
  assign fire = out_valid_o & out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    pass_d = pass_q;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (!in_op_i) begin
            state_d = ST_DIV1;
            pass_d = 2'd0;
          end else if (stat_i.active) begin
            state_d = stat_i.iters_zero ? ST_NOP : ST_ADDR1;
          end
        end
      end
      ST_DIV1: state_d = stat_i.bad ? ST_BAD : ST_DIV2;
      ST_DIV2: begin
        if (!stat_i.div_busy) begin
          pass_d = pass_q + 2'd1;
          if (pass_q == 2'd3) state_d = ST_MUL1;
        end
      end
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_COMMIT;
      ST_COMMIT: state_d = ST_IDLE;
      ST_BAD: if (fire) state_d = ST_IDLE;
      ST_ADDR1: state_d = ST_ADDR2;
      ST_ADDR2: state_d = ST_EMIT0;
      ST_EMIT0: if (fire) state_d = ST_EMIT1;
      ST_EMIT1: if (fire) state_d = ST_EMIT2;
      ST_EMIT2: if (fire) state_d = ST_IDLE;
      ST_NOP: if (fire) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and commands.
  always_comb begin
    ctrl_o = '0;
    in_ready_o = (state_q == ST_IDLE);
    out_valid_o = 1'b0;
    out_kind_o = KIND_WAIT;
    out_run_o = 1'b0;
    out_bad_o = 1'b0;
    out_last_o = 1'b0;
    ctrl_o.load_in = acc & ~in_op_i;
    ctrl_o.step = 1'b0;
    case (state_q)
      ST_DIV1: ctrl_o.div_start = ~stat_i.bad;
      ST_DIV2: begin
        // Each pass hands its result over; the first three also start the next division.
        if (!stat_i.div_busy) begin
          case (pass_q)
            2'd0: ctrl_o.take_rsize = 1'b1;
            2'd1: ctrl_o.take_f = 1'b1;
            2'd2: ctrl_o.take_rc = 1'b1;
            default: ctrl_o.take_lm = 1'b1;
          endcase
        end
      end
      ST_MUL1: ctrl_o.mul1 = 1'b1;
      ST_MUL2: ctrl_o.mul2 = 1'b1;
      ST_COMMIT: ctrl_o.commit = 1'b1;
      ST_BAD: begin
        out_valid_o = 1'b1;
        out_bad_o = 1'b1;
        out_last_o = 1'b1;
      end
      ST_ADDR1: ctrl_o.addr1 = 1'b1;
      ST_ADDR2: ctrl_o.addr2 = 1'b1;
      ST_EMIT0: out_valid_o = 1'b1;
      ST_EMIT1: begin
        out_valid_o = 1'b1;
        out_kind_o = KIND_RUN;
        out_run_o = 1'b1;
      end
      ST_EMIT2: begin
        out_valid_o = 1'b1;
        out_kind_o = KIND_SEND;
        out_last_o = 1'b1;
        ctrl_o.step = fire;
      end
      ST_NOP: begin
        out_valid_o = 1'b1;
        out_kind_o = KIND_NOP;
        out_last_o = 1'b1;
        ctrl_o.step = fire;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pass_q <= '0;
    end else begin
      state_q <= state_d;
      pass_q <= pass_d;
    end
  end

  // A beat is never offered while a new item is being taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(in_ready_o && out_valid_o))
    else $error("input and output active together");
  // A taken wait beat is followed by the run beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT0 && fire) |=> state_q == ST_EMIT1)
    else $error("group order broken");
  // An offered beat holds until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(out_kind_o))
    else $error("beat dropped");
endmodule
`default_nettype wire

FILE: rtl/core/result_tile_instr_generator_top.sv
`default_nettype none
// Result tile instruction generator.
// Input channel in_i carries items: op 0 loads a matrix-multiply descriptor,
// op 1 asks for the next instruction group. Output channel out_o carries one
// instruction per beat; last marks the final beat of an item.
// A good load keeps ready low until its commit: a shared one-bit-per-cycle
// divider runs four passes (region size, fetch count, region count,
// remainder), followed by the multiply states MUL1 and MUL2 and a commit. It
// gives no beat. A bad load offers one error beat after the DIV1 state.
// A step item builds the address in states ADDR1 and ADDR2, then offers
// three beats: wait, run and send. A step with no active run gives no beat.
// A step after the last iteration offers one nop beat in the next cycle.
// The block takes one item at a time; ready is low while an item is in
// progress. When the receiver stalls, the current beat holds until taken and
// the block waits. Reset clears the run state to idle.
module result_tile_instr_generator_top import rtig_pkg::*; #(
  parameter int unsigned ARRAY_ROWS    = 8,
  parameter int unsigned ARRAY_COLS    = 8,
  parameter int unsigned LHS_MEM_DEPTH = 1024,
  parameter int unsigned ACC_BITS      = 32
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  rtig_in_if.sink  in_i,
  rtig_out_if.source out_o
);
  ctrl_t ctrl;
  stat_t stat;
  logic [1:0] kind;
  logic run, bad, last;
  logic [31:0] addr, stride;
  logic bufs;

  rtig_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_i.valid), .in_op_i(in_i.op), .in_ready_o(in_i.ready),
    .out_ready_i(out_o.ready), .out_valid_o(out_o.valid),
    .out_kind_o(kind), .out_run_o(run), .out_bad_o(bad), .out_last_o(last),
    .stat_i(stat), .ctrl_o(ctrl)
  );

  rtig_datapath #(
    .ARRAY_ROWS(ARRAY_ROWS), .ARRAY_COLS(ARRAY_COLS),
    .LHS_MEM_DEPTH(LHS_MEM_DEPTH), .ACC_BITS(ACC_BITS)
  ) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat),
    .row_tiles_i(in_i.row_tiles), .col_tiles_i(in_i.col_tiles),
    .depth_tiles_i(in_i.depth_tiles), .lhs_bits_i(in_i.lhs_bits),
    .result_base_i(in_i.result_base),
    .addr_o(addr), .buf_o(bufs), .stride_o(stride)
  );

  assign out_o.kind = kind;
  assign out_o.dram_addr = run ? addr : 32'd0;
  assign out_o.buffer_sel = run ? bufs : 1'b0;
  assign out_o.dram_stride = run ? stride : 32'd0;
  assign out_o.bad_descriptor = bad;
  assign out_o.last = last;
endmodule
`default_nettype wire

FILE: verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rtig_pkg::*;

  localparam int unsigned ROWS  = 8;
  localparam int unsigned COLS  = 8;
  localparam int unsigned DEPTH = 1024;
  localparam int unsigned ACC_B = 32;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef struct packed {
    logic        op;
    logic [15:0] row_tiles;
    logic [15:0] col_tiles;
    logic [15:0] depth_tiles;
    logic [7:0]  lhs_bits;
    logic [31:0] result_base;
  } cmd_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] dram_addr;
    logic        buffer_sel;
    logic [31:0] dram_stride;
    logic        bad_descriptor;
    logic        last;
  } instr_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rtig_in_if  in_ch ();
  rtig_out_if out_ch ();

  result_tile_instr_generator_top i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  always #5 clk_i = ~clk_i;

  cmd_t   pending_cmds[$];
  instr_t expected_instrs[$];
  int     fail_count = 0;

  // Tile walk state of the generator model.
  bit          run_active;
  logic [15:0] cols_total, rows_total, region_cnt, fetch_cnt, tail_rows;
  logic [15:0] row_pos, col_pos, fetch_pos;
  logic [31:0] base_addr, stride_bytes, iters_left;
  bit          buf_flip;

  function automatic instr_t make_instr(kind_e k, logic [31:0] a, logic b,
                                        logic [31:0] s, logic bad, logic lst);
    instr_t r;
    r.kind = k; r.dram_addr = a; r.buffer_sel = b; r.dram_stride = s;
    r.bad_descriptor = bad; r.last = lst;
    return r;
  endfunction

  // Advance row, column and fetch indices exactly as the hardware walks them.
  function automatic void advance_tile();
    logic [31:0] rc, lf, m;
    rc = region_cnt;
    lf = fetch_pos;
    row_pos = row_pos + 16'd1;
    m = row_pos;
    if (m == rc * (lf + 1) ||
        (m == tail_rows + rc * lf && lf == fetch_cnt - 32'd1)) begin
      row_pos = 16'(rc * lf);
      col_pos = col_pos + 16'd1;
      if (col_pos == cols_total) begin
        col_pos = '0;
        fetch_pos = fetch_pos + 16'd1;
        row_pos = 16'(rc * fetch_pos);
        if (fetch_pos == fetch_cnt) fetch_pos = '0;
      end
    end
  endfunction

  // Work out the instructions an accepted beat causes.
  function automatic void predict_instrs(cmd_t c);
    logic [31:0] tm, rsize, need, f, rc, lm, nrows, ind;
    logic [63:0] total;
    if (c.op == OP_LOAD) begin
      tm = c.row_tiles;
      if (tm == 0 || tm > DEPTH) begin
        run_active = 1'b0;
        expected_instrs.push_back(make_instr(KIND_WAIT, '0, 1'b0, '0, 1'b1, 1'b1));
        return;
      end
      rsize = DEPTH / tm;
      need = c.depth_tiles * c.lhs_bits;
      f = need / rsize + ((need % rsize) != 0 ? 1 : 0);
      if (f > 32'hFFFF) f = 32'hFFFF;
      if (f == 0) f = 1;
      rc = (tm + f - 1) / f;
      lm = tm % rc;
      if (lm != 0) total = 64'(rc) * c.col_tiles * (f - 1) + 64'(lm) * c.col_tiles;
      else total = 64'(rc) * c.col_tiles * f;
      if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
      rows_total = c.row_tiles; cols_total = c.col_tiles;
      base_addr = c.result_base;
      stride_bytes = (ACC_B / 8) * (tm * ROWS);
      fetch_cnt = 16'(f); region_cnt = 16'(rc); tail_rows = 16'(lm);
      iters_left = total[31:0];
      row_pos = '0; col_pos = '0; fetch_pos = '0; buf_flip = 1'b0;
      run_active = 1'b1;
      return;
    end
    if (!run_active) return;
    if (iters_left == 0) begin
      run_active = 1'b0;
      expected_instrs.push_back(make_instr(KIND_NOP, '0, 1'b0, '0, 1'b0, 1'b1));
      return;
    end
    nrows = 32'(rows_total) * ROWS;
    ind = (COLS * 32'(col_pos)) * nrows + ROWS * 32'(row_pos);
    expected_instrs.push_back(make_instr(KIND_WAIT, '0, 1'b0, '0, 1'b0, 1'b0));
    expected_instrs.push_back(make_instr(KIND_RUN, base_addr + ind * (ACC_B / 8),
                                         buf_flip, stride_bytes, 1'b0, 1'b0));
    expected_instrs.push_back(make_instr(KIND_SEND, '0, 1'b0, '0, 1'b0, 1'b1));
    buf_flip = ~buf_flip;
    iters_left = iters_left - 1;
    advance_tile();
  endfunction

  // Driver: bursts of beats separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      {in_ch.op, in_ch.row_tiles, in_ch.col_tiles, in_ch.depth_tiles,
       in_ch.lhs_bits, in_ch.result_base} <= '0;
    end else begin
      automatic bit send_next = 1'b0;
      if (in_ch.valid && in_ch.ready) begin
        predict_instrs(pending_cmds.pop_front());
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_cmds.size() > 0) begin
          send_next = 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
          end
          burst_left--;
          if (burst_left == 0 && $urandom_range(0, 2) != 0) gap_left = $urandom_range(1, 12);
        end
        in_ch.valid <= send_next;
        if (send_next) begin
          {in_ch.op, in_ch.row_tiles, in_ch.col_tiles, in_ch.depth_tiles,
           in_ch.lhs_bits, in_ch.result_base} <= pending_cmds[0];
        end
      end
    end
  end

  // Receiver stalls on its own pattern, with one long hold-off.
  int cyc = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      cyc++;
      if (!hold_done && cyc == 3000) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if ((cyc / 500) % 3 == 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Monitor: compare each accepted beat with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_instrs.size() == 0) begin
        $error("unexpected beat kind=%0d", out_ch.kind);
        fail_count++;
      end else begin
        automatic instr_t e = expected_instrs.pop_front();
        if (out_ch.kind !== e.kind) begin
          $error("kind: expected %0d actual %0d", e.kind, out_ch.kind); fail_count++;
        end
        if (out_ch.dram_addr !== e.dram_addr) begin
          $error("dram_addr: expected %h actual %h", e.dram_addr, out_ch.dram_addr);
          fail_count++;
        end
        if (out_ch.buffer_sel !== e.buffer_sel) begin
          $error("buffer_sel: expected %0d actual %0d", e.buffer_sel, out_ch.buffer_sel);
          fail_count++;
        end
        if (out_ch.dram_stride !== e.dram_stride) begin
          $error("dram_stride: expected %h actual %h", e.dram_stride, out_ch.dram_stride);
          fail_count++;
        end
        if (out_ch.bad_descriptor !== e.bad_descriptor) begin
          $error("bad_descriptor: expected %0d actual %0d", e.bad_descriptor,
                 out_ch.bad_descriptor);
          fail_count++;
        end
        if (out_ch.last !== e.last) begin
          $error("last: expected %0d actual %0d", e.last, out_ch.last); fail_count++;
        end
      end
    end
  end

  function automatic cmd_t load_cmd(logic [15:0] m, logic [15:0] n, logic [15:0] k,
                                    logic [7:0] b, logic [31:0] base);
    cmd_t c;
    c.op = OP_LOAD; c.row_tiles = m; c.col_tiles = n; c.depth_tiles = k;
    c.lhs_bits = b; c.result_base = base;
    return c;
  endfunction

  function automatic cmd_t step_cmd();
    cmd_t c;
    c = cmd_t'(89'({$urandom, $urandom, $urandom}));
    c.op = OP_STEP;
    return c;
  endfunction

  function automatic void add_steps(int count);
    for (int i = 0; i < count; i++) pending_cmds.push_back(step_cmd());
  endfunction

  initial begin
    int kind_sel, steps;
    cmd_t c;
    // Directed part: idle step, bad loads, edge descriptors, run to the nop.
    pending_cmds.push_back(step_cmd());
    pending_cmds.push_back(load_cmd(16'd0, 16'd3, 16'd1, 8'd1, 32'h1000));
    pending_cmds.push_back(load_cmd(16'd1025, 16'd3, 16'd1, 8'd1, 32'h1000));
    pending_cmds.push_back(load_cmd(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, '1));
    pending_cmds.push_back(load_cmd(16'd3, 16'd2, 16'd0, 8'd4, 32'hFFFF_FFF0));
    add_steps(8);
    pending_cmds.push_back(load_cmd(16'd1024, 16'd1, 16'hFFFF, 8'hFF, 32'h0));
    add_steps(3);
    pending_cmds.push_back(load_cmd(16'd4, 16'd2, 16'd300, 8'd8, 32'h8000_0000));
    add_steps(6);
    pending_cmds.push_back(load_cmd(16'd1, 16'd0, 16'd1, 8'd1, 32'h5));
    add_steps(2);
    // Random part: mostly loads followed by a random number of steps.
    while (pending_cmds.size() < 440) begin
      kind_sel = $urandom_range(0, 9);
      if (kind_sel == 0) begin
        c = cmd_t'(89'({$urandom, $urandom, $urandom}));
        c.op = OP_LOAD;
        pending_cmds.push_back(c);
      end else if (kind_sel == 1) begin
        pending_cmds.push_back(step_cmd());
      end else begin
        c = load_cmd(16'($urandom_range(1, 12)), 16'($urandom_range(0, 4)),
                     16'($urandom_range(0, 600)), 8'($urandom_range(0, 255)), $urandom);
        if ($urandom_range(0, 5) == 0) c.row_tiles = 16'($urandom_range(1, 1024));
        pending_cmds.push_back(c);
        steps = $urandom_range(1, 14);
        add_steps(steps);
      end
    end
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_cmds.size() == 0);
    wait (expected_instrs.size() == 0);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && expected_instrs.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("testbench failed");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/rtig_pkg.sv
rtl/core/rtig_if.sv
rtl/core/rtig_div.sv
rtl/core/rtig_datapath.sv
rtl/core/rtig_ctrl.sv
rtl/core/result_tile_instr_generator_top.sv
verif/testbench.sv
